/* src/http_rlp_pkg.sv */
`default_nettype none
package http_rlp_pkg;

  localparam int unsigned LINE_MAX = 128;
  localparam int unsigned RES_MAX  = 3;

  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_PCT = 8'h25;

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_METHOD = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_PATH   = 3'd3;
  localparam logic [2:0] PH_REST   = 3'd4;
  localparam logic [2:0] PH_EMPTY  = 3'd5;

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  localparam logic [1:0] KIND_PATH  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_EMPTY   = 2'd0;
  localparam logic [1:0] ERR_TOOLONG = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;

  localparam logic [2:0] METH_UNKNOWN = 3'd0;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] path_byte;
    logic [2:0] method_code;
    logic [7:0] path_length;
    logic [1:0] error_code;
    logic       last;
  } rslt_t;

  typedef struct packed {
    logic [1:0]          cnt;
    rslt_t [RES_MAX-1:0] res;
  } batch_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  // 16 marks a non-hex byte
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b >= "0" && b <= "9") v = 5'(b - "0");
    else if (b >= "A" && b <= "F") v = 5'(b - "A" + 8'd10);
    else if (b >= "a" && b <= "f") v = 5'(b - "a" + 8'd10);
    return v;
  endfunction

  function automatic logic [2:0] method_len(input logic [2:0] idx);
    logic [2:0] l;
    case (idx)
      3'd0:    l = 3'd3;
      3'd1:    l = 3'd4;
      3'd2:    l = 3'd3;
      3'd3:    l = 3'd6;
      3'd4:    l = 3'd4;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] method_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [47:0] s;
    logic [7:0]  c;
    case (idx)
      3'd0:    s = {24'h0, "TEG"};
      3'd1:    s = {16'h0, "TSOP"};
      3'd2:    s = {24'h0, "TUP"};
      3'd3:    s = "ETELED";
      3'd4:    s = {16'h0, "EVOM"};
      default: s = '0;
    endcase
    c = 8'h0;
    if (pos < 3'd6) c = s[pos*8 +: 8];
    return c;
  endfunction

  function automatic rslt_t mk_path(input logic [7:0] b, input logic [2:0] m,
                                    input logic [7:0] len);
    rslt_t r;
    r = '0;
    r.result_kind = KIND_PATH;
    r.path_byte   = b;
    r.method_code = m;
    r.path_length = len;
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/http_rlp_core.sv */
`default_nettype none
module http_rlp_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    take_i,
  input  wire  [7:0]             line_byte_i,
  input  wire                    timed_out_i,
  output http_rlp_pkg::batch_t   batch_o
);

  logic [2:0] phase_q, phase_d;
  logic [4:0] cand_q, cand_d;
  logic [2:0] mpos_q, mpos_d;
  logic [1:0] esc_q, esc_d;
  logic [7:0] held_q, held_d;
  logic [7:0] lcnt_q, lcnt_d;
  logic [7:0] dcnt_q, dcnt_d;
  logic [2:0] mres_q, mres_d;

  http_rlp_pkg::rslt_t [http_rlp_pkg::RES_MAX-1:0] res;
  logic [1:0] nres;
  logic       path_go;
  logic       plain;
  logic [7:0] b;
  logic [7:0] v;
  logic [4:0] hb;
  logic [4:0] hh;

  always_comb begin
    phase_d = phase_q;
    cand_d  = cand_q;
    mpos_d  = mpos_q;
    esc_d   = esc_q;
    held_d  = held_q;
    lcnt_d  = lcnt_q;
    dcnt_d  = dcnt_q;
    mres_d  = mres_q;
    res     = '0;
    nres    = 2'd0;
    path_go = 1'b0;
    plain   = 1'b0;
    b       = line_byte_i;
    hb      = http_rlp_pkg::hex_val(line_byte_i);
    hh      = http_rlp_pkg::hex_val(held_q);
    v       = {hh[3:0], hb[3:0]};

    if (take_i) begin
      if (timed_out_i) begin
        res[0].result_kind = http_rlp_pkg::KIND_ERROR;
        res[0].error_code  = http_rlp_pkg::ERR_TIMEOUT;
        res[0].last        = 1'b1;
        nres = 2'd1;
      end else if (b == http_rlp_pkg::CHAR_CR) begin
        nres = 2'd0;
      end else if (b == http_rlp_pkg::CHAR_LF) begin
        if (lcnt_q == 8'd0 || phase_q == http_rlp_pkg::PH_EMPTY) begin
          res[0].result_kind = http_rlp_pkg::KIND_ERROR;
          res[0].error_code  = http_rlp_pkg::ERR_EMPTY;
          res[0].last        = 1'b1;
          nres = 2'd1;
        end else begin
          if (phase_q == http_rlp_pkg::PH_PATH && esc_q != http_rlp_pkg::ESC_NONE) begin
            dcnt_d = dcnt_d + 8'd1;
            res[nres] = http_rlp_pkg::mk_path(http_rlp_pkg::CHAR_PCT, mres_q, dcnt_d);
            nres = nres + 2'd1;
            if (esc_q == http_rlp_pkg::ESC_DIGIT) begin
              dcnt_d = dcnt_d + 8'd1;
              res[nres] = http_rlp_pkg::mk_path(held_q, mres_q, dcnt_d);
              nres = nres + 2'd1;
            end
          end
          res[nres].result_kind = http_rlp_pkg::KIND_DONE;
          res[nres].method_code = mres_q;
          res[nres].path_length = dcnt_d;
          res[nres].last        = 1'b1;
          nres = nres + 2'd1;
        end
      end else if ({1'b0, lcnt_q} + 9'd1 >= 9'(http_rlp_pkg::LINE_MAX)) begin
        res[0].result_kind = http_rlp_pkg::KIND_ERROR;
        res[0].error_code  = http_rlp_pkg::ERR_TOOLONG;
        res[0].last        = 1'b1;
        nres = 2'd1;
      end else begin
        lcnt_d = lcnt_q + 8'd1;
        unique case (phase_q)
          http_rlp_pkg::PH_LEAD: begin
            if (b == 8'd0) begin
              phase_d = (lcnt_d == 8'd1) ? http_rlp_pkg::PH_EMPTY : http_rlp_pkg::PH_REST;
            end else if (!http_rlp_pkg::is_ws(b)) begin
              phase_d = http_rlp_pkg::PH_METHOD;
            end
          end
          http_rlp_pkg::PH_METHOD: begin
            if (b == 8'd0) phase_d = http_rlp_pkg::PH_REST;
            else if (http_rlp_pkg::is_ws(b)) phase_d = http_rlp_pkg::PH_GAP;
          end
          http_rlp_pkg::PH_GAP: begin
            if (b == 8'd0) begin
              phase_d = http_rlp_pkg::PH_REST;
            end else if (!http_rlp_pkg::is_ws(b)) begin
              phase_d = http_rlp_pkg::PH_PATH;
              path_go = 1'b1;
            end
          end
          http_rlp_pkg::PH_PATH: path_go = 1'b1;
          default: phase_d = phase_q;
        endcase

        // method token matching
        if (phase_d == http_rlp_pkg::PH_METHOD) begin
          for (int i = 0; i < 5; i++) begin
            if (cand_q[i] && mpos_q < http_rlp_pkg::method_len(3'(i))) begin
              if (http_rlp_pkg::method_char(3'(i), mpos_q) != b) begin
                cand_d[i] = 1'b0;
              end else if ({1'b0, mpos_q} + 4'd1 == {1'b0, http_rlp_pkg::method_len(3'(i))}
                           && mres_d == http_rlp_pkg::METH_UNKNOWN) begin
                mres_d = 3'(i + 1);
              end
            end
          end
          if (mpos_q < 3'd7) mpos_d = mpos_q + 3'd1;
        end

        // percent decoding
        if (path_go) begin
          unique case (esc_q)
            http_rlp_pkg::ESC_PCT: begin
              if (hb < 5'd16) begin
                held_d = b;
                esc_d  = http_rlp_pkg::ESC_DIGIT;
              end else begin
                esc_d  = http_rlp_pkg::ESC_NONE;
                dcnt_d = dcnt_d + 8'd1;
                res[nres] = http_rlp_pkg::mk_path(http_rlp_pkg::CHAR_PCT, mres_q, dcnt_d);
                nres = nres + 2'd1;
                plain = 1'b1;
              end
            end
            http_rlp_pkg::ESC_DIGIT: begin
              esc_d = http_rlp_pkg::ESC_NONE;
              if (hb < 5'd16) begin
                if (v == 8'd0 || http_rlp_pkg::is_ws(v)) begin
                  phase_d = http_rlp_pkg::PH_REST;
                end else begin
                  dcnt_d = dcnt_d + 8'd1;
                  res[nres] = http_rlp_pkg::mk_path(v, mres_q, dcnt_d);
                  nres = nres + 2'd1;
                end
              end else begin
                dcnt_d = dcnt_d + 8'd1;
                res[nres] = http_rlp_pkg::mk_path(http_rlp_pkg::CHAR_PCT, mres_q, dcnt_d);
                nres = nres + 2'd1;
                dcnt_d = dcnt_d + 8'd1;
                res[nres] = http_rlp_pkg::mk_path(held_q, mres_q, dcnt_d);
                nres = nres + 2'd1;
                plain = 1'b1;
              end
            end
            default: plain = 1'b1;
          endcase
          if (plain) begin
            if (b == 8'd0 || http_rlp_pkg::is_ws(b)) begin
              phase_d = http_rlp_pkg::PH_REST;
            end else if (b == http_rlp_pkg::CHAR_PCT) begin
              esc_d = http_rlp_pkg::ESC_PCT;
            end else begin
              dcnt_d = dcnt_d + 8'd1;
              res[nres] = http_rlp_pkg::mk_path(b, mres_q, dcnt_d);
              nres = nres + 2'd1;
            end
          end
        end
      end

      // a final result starts a new line
      if (nres != 2'd0 && res[nres-2'd1].last) begin
        phase_d = http_rlp_pkg::PH_LEAD;
        cand_d  = 5'h1f;
        mpos_d  = 3'd0;
        esc_d   = http_rlp_pkg::ESC_NONE;
        held_d  = 8'd0;
        lcnt_d  = 8'd0;
        dcnt_d  = 8'd0;
        mres_d  = http_rlp_pkg::METH_UNKNOWN;
      end
    end
  end

  assign batch_o = {nres, res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= http_rlp_pkg::PH_LEAD;
      cand_q  <= 5'h1f;
      mpos_q  <= 3'd0;
      esc_q   <= http_rlp_pkg::ESC_NONE;
      held_q  <= 8'd0;
      lcnt_q  <= 8'd0;
      dcnt_q  <= 8'd0;
      mres_q  <= http_rlp_pkg::METH_UNKNOWN;
    end else begin
      phase_q <= phase_d;
      cand_q  <= cand_d;
      mpos_q  <= mpos_d;
      esc_q   <= esc_d;
      held_q  <= held_d;
      lcnt_q  <= lcnt_d;
      dcnt_q  <= dcnt_d;
      mres_q  <= mres_d;
    end
  end

endmodule
`default_nettype wire

/* src/http_rlp_outq.sv */
`default_nettype none
module http_rlp_outq (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire http_rlp_pkg::batch_t  batch_i,
  output logic                       room_o,
  output logic                       valid_o,
  input  wire                        ready_i,
  output http_rlp_pkg::rslt_t        head_o
);

  http_rlp_pkg::rslt_t mem [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign room_o  = (cnt_q <= 3'd1);
  assign valid_o = (cnt_q != 3'd0);
  assign head_o  = mem[rd_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = wr_q + batch_i.cnt;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, batch_i.cnt} - {2'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < http_rlp_pkg::RES_MAX; k++) begin
      if (2'(k) < batch_i.cnt) mem[wr_q + 2'(k)] <= batch_i.res[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* src/http_request_line_parser.sv */
`default_nettype none
// channel   | dir | tdata                                          | tuser        | tlast
// s_axis    | in  | line_byte[7:0]                                 | timed_out    | -
// m_axis    | out | path_byte, method_code, path_length, error_code | result_kind  | last
//
// one input item per cycle while s_axis_tready is high; its results enter the queue
// a four-entry result queue drains one result per cycle while m_axis_tready is high;
// s_axis_tready drops while it holds more than one result, since one item can yield three
// reset clears the line state and empties the queue
// m_axis stalls only pause input once two results wait in the queue
module http_request_line_parser (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // line_byte[7:0]
  input  wire  [0:0]  s_axis_tuser,   // timed_out[0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // path_byte[7:0] method_code[10:8]
                                      // path_length[18:11] error_code[20:19]
  output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
  output logic        m_axis_tlast    // last
);

  http_rlp_pkg::batch_t batch;
  http_rlp_pkg::rslt_t  head;
  logic                 room;
  logic                 take;

  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  http_rlp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .line_byte_i (s_axis_tdata),
    .timed_out_i (s_axis_tuser[0]),
    .batch_o     (batch)
  );

  http_rlp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .batch_i (batch),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {3'b000, head.error_code, head.path_length,
                         head.method_code, head.path_byte};
  assign m_axis_tuser = head.result_kind;
  assign m_axis_tlast = head.last;

endmodule
`default_nettype wire

/* dv/http_request_line_parser_test.sv */
`timescale 1ns / 1ps

module http_request_line_parser_test;
  import http_rlp_pkg::*;

  localparam int LIMIT = 200000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [7:0] ch;
    logic       expired;
  } rx_item_t;

  class request_line_decoder;
    string      meth_name[5];
    logic [2:0] phase;
    logic [4:0] alive;
    logic [2:0] token_pos;
    logic [1:0] esc;
    logic [7:0] held;
    logic [7:0] stored;
    logic [7:0] decoded;
    logic [2:0] meth;
    rslt_t      expected_results[$];
    int         mismatches;
    int         printed;

    function new();
      meth_name = '{"GET", "POST", "PUT", "DELETE", "MOVE"};
      mismatches = 0;
      printed = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase = PH_LEAD;
      alive = 5'h1f;
      token_pos = '0;
      esc = ESC_NONE;
      held = '0;
      stored = '0;
      decoded = '0;
      meth = METH_UNKNOWN;
    endfunction

    function bit is_space(logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function int hex_digit(logic [7:0] b);
      if (b >= 8'd48 && b <= 8'd57) return int'(b) - 48;
      if (b >= 8'd65 && b <= 8'd70) return int'(b) - 55;
      if (b >= 8'd97 && b <= 8'd102) return int'(b) - 87;
      return -1;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] pb, logic [2:0] mc, logic [7:0] pl,
                       logic [1:0] ec, logic lst);
      rslt_t r;
      r.result_kind = kind;
      r.path_byte   = pb;
      r.method_code = mc;
      r.path_length = pl;
      r.error_code  = ec;
      r.last        = lst;
      expected_results.push_back(r);
    endfunction

    function void emit(logic [7:0] b);
      decoded = decoded + 8'd1;
      push(KIND_PATH, b, meth, decoded, '0, 1'b0);
    endfunction

    function void path_plain(logic [7:0] b);
      if (b == 8'd0 || is_space(b)) phase = PH_REST;
      else if (b == CHAR_PCT) esc = ESC_PCT;
      else emit(b);
    endfunction

    function void path_step(logic [7:0] b);
      int v;
      case (esc)
        ESC_PCT: begin
          if (hex_digit(b) >= 0) begin
            held = b;
            esc = ESC_DIGIT;
          end else begin
            esc = ESC_NONE;
            emit(CHAR_PCT);
            path_plain(b);
          end
        end
        ESC_DIGIT: begin
          esc = ESC_NONE;
          if (hex_digit(b) >= 0) begin
            v = hex_digit(held) * 16 + hex_digit(b);
            if (v == 0 || is_space(8'(v))) phase = PH_REST;
            else emit(8'(v));
          end else begin
            emit(CHAR_PCT);
            emit(held);
            path_plain(b);
          end
        end
        default: path_plain(b);
      endcase
    endfunction

    function void method_step(logic [7:0] b);
      int i;
      int p;
      p = token_pos;
      for (i = 0; i < 5; i++) begin
        if (!alive[i] || p >= meth_name[i].len()) continue;
        if (meth_name[i][p] != b) alive[i] = 1'b0;
        else if (p + 1 == meth_name[i].len() && meth == METH_UNKNOWN) meth = 3'(i + 1);
      end
      if (token_pos < 3'd7) token_pos = token_pos + 3'd1;
    endfunction

    function void take_item(logic [7:0] b, logic expired);
      if (expired) begin
        push(KIND_ERROR, '0, '0, '0, ERR_TIMEOUT, 1'b1);
        clear_line();
        return;
      end
      if (b == CHAR_CR) return;
      if (b == CHAR_LF) begin
        if (stored == 8'd0 || phase == PH_EMPTY) begin
          push(KIND_ERROR, '0, '0, '0, ERR_EMPTY, 1'b1);
        end else begin
          if (phase == PH_PATH && esc == ESC_PCT) begin
            emit(CHAR_PCT);
          end else if (phase == PH_PATH && esc == ESC_DIGIT) begin
            emit(CHAR_PCT);
            emit(held);
          end
          push(KIND_DONE, '0, meth, decoded, '0, 1'b1);
        end
        clear_line();
        return;
      end
      if (int'(stored) + 1 >= int'(LINE_MAX)) begin
        push(KIND_ERROR, '0, '0, '0, ERR_TOOLONG, 1'b1);
        clear_line();
        return;
      end
      stored = stored + 8'd1;
      case (phase)
        PH_LEAD: begin
          if (b == 8'd0) phase = (stored == 8'd1) ? PH_EMPTY : PH_REST;
          else if (!is_space(b)) begin
            phase = PH_METHOD;
            method_step(b);
          end
        end
        PH_METHOD: begin
          if (b == 8'd0) phase = PH_REST;
          else if (is_space(b)) phase = PH_GAP;
          else method_step(b);
        end
        PH_GAP: begin
          if (b == 8'd0) phase = PH_REST;
          else if (!is_space(b)) begin
            phase = PH_PATH;
            path_step(b);
          end
        end
        PH_PATH: path_step(b);
        default: ;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (printed < 40) begin
        $display("[%0t] %s", $time, msg);
        printed++;
      end
    endtask

    task compare_field(string what, int got, int want);
      if (got != want) report($sformatf("%s: got %0d, expected %0d", what, got, want));
    endtask

    task check_result(rslt_t got);
      rslt_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected item: kind %0d byte %0d", got.result_kind, got.path_byte));
        return;
      end
      want = expected_results.pop_front();
      compare_field("result_kind", got.result_kind, want.result_kind);
      compare_field("path_byte", got.path_byte, want.path_byte);
      compare_field("method_code", got.method_code, want.method_code);
      compare_field("path_length", got.path_length, want.path_length);
      compare_field("error_code", got.error_code, want.error_code);
      compare_field("last", got.last, want.last);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  rslt_t               seen;
  request_line_decoder decoder;
  bit                  steady = 1'b0;
  int                  cycles = 0;
  int                  sent = 0;
  rx_item_t            line_q[$];
  string               methods[5] = '{"GET", "POST", "PUT", "DELETE", "MOVE"};

  http_request_line_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign seen = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tdata[18:11],
                 m_axis_tdata[20:19], m_axis_tlast};

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) decoder.take_item(s_axis_tdata, s_axis_tuser[0]);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) decoder.check_result(seen);
  end

  task automatic send_item(input logic [7:0] b, input logic expired);
    while (!steady && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'($urandom);
      s_axis_tuser <= 1'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= expired;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic void add(input logic [7:0] b);
    line_q.push_back('{ch: b, expired: 1'b0});
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add(s[i]);
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0: return 8'd9;
      1: return 8'd11;
      2: return 8'd12;
      default: return 8'd32;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(48 + v);
    return 8'(($urandom_range(0, 1) ? 65 : 97) + v - 10);
  endfunction

  function automatic void make_line(input int idx);
    int    pick;
    int    n;
    int    i;
    int    v;
    int    m;
    string name;
    line_q.delete();
    pick = $urandom_range(0, 99);
    if (idx % 20 == 2) begin
      add_text("GET ");
      n = $urandom_range(118, 135);
      for (i = 0; i < n; i++) add(8'($urandom_range(33, 126)));
      add(CHAR_LF);
    end else if (pick < 8) begin
      n = $urandom_range(1, 16);
      for (i = 0; i < n; i++) add(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) add(CHAR_LF);
    end else if (pick < 12) begin
      case ($urandom_range(0, 3))
        0: add(CHAR_LF);
        1: add_text("\r\n");
        2: line_q.push_back('{ch: 8'($urandom), expired: 1'b1});
        default: begin
          add(8'h00);
          add(CHAR_LF);
        end
      endcase
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add(pick_space());
      m = $urandom_range(0, 6);
      if (m < 5) begin
        name = methods[m];
        n = name.len();
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n - 1);
        for (i = 0; i < n; i++) add(name[i]);
        if ($urandom_range(0, 9) == 0) add(8'($urandom_range(65, 90)));
      end else if (m == 5) begin
        repeat ($urandom_range(1, 7)) add(8'($urandom_range(65, 90)));
      end else begin
        add_text("PO");
        add(8'h00);
      end
      repeat ($urandom_range(1, 2)) add(pick_space());
      add("/");
      n = $urandom_range(0, 14);
      for (i = 0; i < n; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          add(8'($urandom_range(33, 126)));
        end else if (pick < 80) begin
          v = $urandom_range(0, 255);
          add(CHAR_PCT);
          add(hex_char(v >> 4));
          add(hex_char(v & 15));
        end else if (pick < 88) begin
          add(CHAR_PCT);
          if ($urandom_range(0, 1)) add(hex_char($urandom_range(0, 15)));
          add(8'($urandom_range(103, 122)));
        end else if (pick < 92) begin
          add(CHAR_PCT);
          if ($urandom_range(0, 1)) add(hex_char($urandom_range(0, 15)));
        end else if (pick < 96) begin
          add(pick_space());
        end else begin
          add(8'h00);
        end
      end
      if ($urandom_range(0, 1)) add_text(" HTTP/1.1");
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        line_q.push_back('{ch: 8'($urandom), expired: 1'b1});
      end else begin
        if (pick < 60) add(CHAR_CR);
        add(CHAR_LF);
      end
    end
  endfunction

  initial begin
    int idx;
    int first;
    decoder = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty line, timeout, zero first byte
    send_item(CHAR_LF, 1'b0);
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(CHAR_LF, 1'b0);
    // bad escape with a held digit gives three items at once
    send_text(" G %4z\r\n");
    // escape still open at end of line
    send_text("PUT %\n");
    send_text("M %a\n");
    // decoded 0xff, then a raw zero ends the path
    send_text("D %fF");
    send_item(8'h00, 1'b0);
    send_text("q\n");

    first = sent;
    idx = 0;
    while (sent - first < RANDOM_ITEMS) begin
      steady = (sent - first >= 150) && (sent - first < 250);
      make_line(idx);
      foreach (line_q[k]) send_item(line_q[k].ch, line_q[k].expired);
      idx++;
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (decoder.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (decoder.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
